[design/frb_pkg.sv]
// ----------------------------------------------------------------------------
// frb_pkg
// Shared sizes, types and helpers for the drop-oldest frame ring buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

  // Storage geometry
  localparam int MAX_SLOTS  = 1024;
  localparam int FRAME_BITS = 64;

  // Port field widths
  localparam int FRAME_W   = 64;
  localparam int CFG_W     = 11;
  localparam int AVAIL_W   = 10;
  localparam int CNT_W     = 32;
  localparam int AVAIL_MAX = (1 << AVAIL_W) - 1;

  // Pointer and capacity widths
  localparam int PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CAP_W = PTR_W + 1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [AVAIL_W-1:0] avail_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FRAME_W-1:0] frame_t;

  // Memory access request from control to store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    ptr_t addr;
  } mem_req_t;

  // Outcome of one item
  typedef struct packed {
    logic write_ok;
    logic read_valid;
  } item_res_t;

  // Queue status after the latest item
  typedef struct packed {
    avail_t avail;
    cnt_t   written;
    cnt_t   dropped;
  } status_t;

  // Register value clamped to 1..MAX_SLOTS
  function automatic cap_t clamp_cap(input cfg_t cfg);
    cap_t res;
    if (cfg == '0) begin
      res = cap_t'(1);
    end else if (int'(cfg) > MAX_SLOTS) begin
      res = cap_t'(MAX_SLOTS);
    end else begin
      res = cap_t'(cfg);
    end
    return res;
  endfunction

  // Pointer plus one, wrapping at the capacity
  function automatic ptr_t bump(input ptr_t p, input cap_t cap);
    cap_t n;
    ptr_t res;
    n = {1'b0, p} + cap_t'(1);
    if (n >= cap) begin
      res = '0;
    end else begin
      res = n[PTR_W-1:0];
    end
    return res;
  endfunction

  // Frames held, saturated to the output width
  function automatic avail_t frames_held(input ptr_t wp, input ptr_t rp, input cap_t cap);
    cap_t   diff;
    avail_t res;
    if (wp >= rp) begin
      diff = {1'b0, wp} - {1'b0, rp};
    end else begin
      diff = cap - ({1'b0, rp} - {1'b0, wp});
    end
    if (int'(diff) > AVAIL_MAX) begin
      res = avail_t'(AVAIL_MAX);
    end else begin
      res = avail_t'(diff);
    end
    return res;
  endfunction

endpackage

[design/frb_store.sv]
// ----------------------------------------------------------------------------
// frb_store
// Frame memory: one port, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module frb_store (
  input  logic             clk,
  input  frb_pkg::mem_req_t req,
  input  frb_pkg::frame_t   wdata,
  output frb_pkg::frame_t   rdata
);
  import frb_pkg::*;

  logic [FRAME_BITS-1:0] mem [MAX_SLOTS];
  logic [FRAME_BITS-1:0] rd_q;

  // Write or read the addressed slot
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= wdata[FRAME_BITS-1:0];
    end
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

  assign rdata = FRAME_W'(rd_q);

endmodule

[design/frb_ctrl.sv]
// ----------------------------------------------------------------------------
// frb_ctrl
// Ring pointers, capacity, totals and the per-item write/read decision.
// ----------------------------------------------------------------------------
module frb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  frb_pkg::cfg_t      cfg_wdata,
  input  logic               item_go,
  input  logic               item_action,
  output frb_pkg::mem_req_t  req,
  output frb_pkg::item_res_t res,
  output frb_pkg::status_t   status
);
  import frb_pkg::*;

  cap_t cap;
  ptr_t wr_ptr;
  ptr_t rd_ptr;
  cnt_t written;
  cnt_t dropped;

  ptr_t wr_bump;
  ptr_t rd_bump;
  logic full;
  logic empty;
  logic is_read;

  // Decision for the offered item
  assign wr_bump = bump(wr_ptr, cap);
  assign rd_bump = bump(rd_ptr, cap);
  assign full    = (wr_bump == rd_ptr);
  assign empty   = (rd_ptr == wr_ptr);
  assign is_read = item_action;

  assign res.write_ok   = !is_read && !full;
  assign res.read_valid = is_read && !empty;

  assign req.wr_en = item_go && !is_read && !full;
  assign req.rd_en = item_go && is_read && !empty;
  assign req.addr  = is_read ? rd_ptr : wr_ptr;

  // Pointers, capacity and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= cap_t'(MAX_SLOTS);
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      written <= '0;
      dropped <= '0;
    end else if (cfg_we) begin
      cap    <= clamp_cap(cfg_wdata);
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (item_go) begin
      if (!is_read) begin
        if (full) begin
          // overflow: discard oldest, refuse new
          rd_ptr  <= rd_bump;
          dropped <= dropped + cnt_t'(1);
        end else begin
          wr_ptr  <= wr_bump;
          written <= written + cnt_t'(1);
        end
      end else if (!empty) begin
        rd_ptr <= rd_bump;
      end
    end
  end

  assign status.avail   = frames_held(wr_ptr, rd_ptr, cap);
  assign status.written = written;
  assign status.dropped = dropped;

  // Checks
  a_wr_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wr_ptr} < cap) else $error("write pointer beyond capacity");

  a_rd_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rd_ptr} < cap) else $error("read pointer beyond capacity");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    item_go && !cfg_we && !is_read && full |=>
      (dropped == $past(dropped) + cnt_t'(1)) && $stable(written))
    else $error("overflow did not bump drop total alone");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    item_go && !cfg_we && !is_read && !full |=>
      (written == $past(written) + cnt_t'(1)) && $stable(dropped))
    else $error("stored write did not bump written total alone");

endmodule

[design/frame_ring_buffer_drop_oldest.sv]
// ----------------------------------------------------------------------------
// frame_ring_buffer_drop_oldest
// Circular frame queue over a configurable number of slots, dropping the
// oldest frame on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: s_axis_tuser[0] selects write (0) or read
//   (1), s_axis_tdata carries the frame word. Each item yields exactly one
//   result item on m_axis with the write/read outcome, the frame read, the
//   frames held and the written and dropped totals.
//   cfg_we/cfg_wdata set the number of ring slots in use (0 acts as 1, values
//   above 1024 act as 1024) and empty the queue; write only while idle.
// Timing:
//   The frame memory has one port and a registered read. An accepted item
//   passes through the holding stage and the output register to m_axis.
//   Sustained rate is one item per cycle while m_axis_tready stays high, set
//   by the single memory access per item; a one-entry holding stage between
//   memory and the output register keeps input open while a result waits.
// Reset:
//   rst empties the queue, clears both totals and sets 1024 slots. Stored
//   frame words are not cleared, so no clearing pass is needed.
// Stall:
//   When m_axis_tready stays low, one more item is taken into the holding
//   stage, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module frame_ring_buffer_drop_oldest (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  frb_pkg::cfg_t       cfg_wdata,      // active_capacity
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // [63:0] frame_in
  input  logic [0:0]          s_axis_tuser,   // [0] action
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [143:0]        m_axis_tdata,   // [63:0] frame_out, [73:64] frames_available,
                                              // [105:74] frames_written_total,
                                              // [137:106] frames_dropped_total, rest zero
  output logic [1:0]          m_axis_tuser    // [0] write_ok, [1] read_valid
);
  import frb_pkg::*;

  mem_req_t  req;
  item_res_t res;
  status_t   status;
  frame_t    rd_data;
  logic      item_go;

  // holding stage
  logic      s1_valid;
  logic      s1_fresh;
  item_res_t s1_res;
  frame_t    s1_frame;
  frame_t    s1_data;
  logic      s1_move;

  // output register
  logic      out_valid;
  logic      out_free;
  item_res_t out_res;
  frame_t    out_frame;
  status_t   out_status;

  frb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_go     (item_go),
    .item_action (s_axis_tuser[0]),
    .req         (req),
    .res         (res),
    .status      (status)
  );

  frb_store u_store (
    .clk   (clk),
    .req   (req),
    .wdata (s_axis_tdata),
    .rdata (rd_data)
  );

  // Handshake
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_move       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || s1_move;
  assign item_go       = s_axis_tvalid && s_axis_tready;

  // Memory data is live in the cycle after the access, then held locally
  assign s1_data = s1_fresh ? rd_data : s1_frame;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_fresh  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_fresh <= item_go;
      if (item_go) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (item_go) begin
      s1_res <= res;
    end
    if (s1_fresh) begin
      s1_frame <= rd_data;
    end
    if (s1_move) begin
      out_res    <= s1_res;
      out_frame  <= s1_res.read_valid ? s1_data : '0;
      out_status <= status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_res.read_valid, out_res.write_ok};
  assign m_axis_tdata  = {6'b0, out_status.dropped, out_status.written,
                          out_status.avail, out_frame};

  // Checks
  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_res))
    else $error("held item lost while output stalled");

  a_fresh_follows_accept: assert property (@(posedge clk) disable iff (rst)
    item_go |=> s1_fresh && s1_valid)
    else $error("accepted item not in holding stage");

  a_outcome_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.write_ok && out_res.read_valid))
    else $error("result flags both set");

endmodule
